### rtl/bsfp4_pkg.sv
// shared types, constants and decode functions of the fp4 operand expander
package bsfp4_pkg;

  // matrix geometry and scale store sizing
  localparam int unsigned MaxDim     = 1024;
  localparam int unsigned ScaleBlock = 32;  // power of two
  localparam int unsigned PosW       = $clog2(MaxDim);
  localparam int unsigned DimW       = PosW + 1;
  localparam int unsigned ScaleShift = $clog2(ScaleBlock);
  localparam int unsigned BlocksMax  = (MaxDim + ScaleBlock - 1) / ScaleBlock;
  localparam int unsigned BlockW     = $clog2(BlocksMax) + 1;
  localparam int unsigned CodesMax   = MaxDim * BlocksMax;
  localparam int unsigned CodeIdxW   = $clog2(CodesMax);
  localparam int unsigned FillW      = CodeIdxW + 1;
  localparam int unsigned StoreDepth = CodesMax / 4;
  localparam int unsigned StoreAddrW = $clog2(StoreDepth);
  localparam int unsigned ByteW      = 8;
  localparam int unsigned NibW       = 4;
  localparam int unsigned ValueW     = 7;

  // queue between front and back, depth is a power of two
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = QPtrW + 1;

  // configuration port
  localparam int unsigned PaddrW = 4;
  localparam int unsigned PdataW = 32;
  localparam logic [1:0] RegMode = 2'd0;
  localparam logic [1:0] RegRows = 2'd1;
  localparam logic [1:0] RegCols = 2'd2;

  localparam logic [1:0] ModeRow = 2'd0;
  localparam logic [1:0] ModeCol = 2'd1;

  typedef enum logic [1:0] {
    OpScale    = 2'd0,
    OpMantissa = 2'd1,
    OpRestart  = 2'd2
  } opcode_e;

  typedef struct packed {
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
  } pos_t;

  // one candidate element as classified by the front
  typedef struct packed {
    logic [NibW-1:0] nib;
    pos_t            pos;
    logic            last;
    logic [1:0]      sub;
  } slot_req_t;

  typedef struct packed {
    logic [1:0]      mask;
    logic            use_scale;
    slot_req_t [1:0] slot;
  } elem_req_t;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    pos_t                     pos;
    logic                     last;
  } elem_t;

  typedef struct packed {
    logic [1:0]  mask;
    elem_t [1:0] slot;
  } queue_entry_t;

  typedef struct packed {
    logic             full;
    logic             r_valid;
    logic [QCntW-1:0] count;
  } back_status_t;

  // e2m1 codes for 0.5 and 1.5 of either sign and for negative zero are rejected
  function automatic logic e2m1_ok(logic [NibW-1:0] nib);
    logic ok;
    case (nib)
      4'h1, 4'h3, 4'h8, 4'h9, 4'hB: ok = 1'b0;
      default:                      ok = 1'b1;
    endcase
    return ok;
  endfunction

  function automatic logic signed [NibW-1:0] e2m1_value(logic [NibW-1:0] nib);
    logic signed [NibW-1:0] v;
    case (nib)
      4'h2:    v = 4'sd1;
      4'h4:    v = 4'sd2;
      4'h5:    v = 4'sd3;
      4'h6:    v = 4'sd4;
      4'h7:    v = 4'sd6;
      4'hA:    v = -4'sd1;
      4'hC:    v = -4'sd2;
      4'hD:    v = -4'sd3;
      4'hE:    v = -4'sd4;
      4'hF:    v = -4'sd6;
      default: v = 4'sd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/bsfp4_ram.sv
// generic ram, one write port and two registered read ports
module bsfp4_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr0_i,
  input  logic [$clog2(Depth)-1:0] rd_addr1_i,
  output logic [Width-1:0]         rd_data0_o,
  output logic [Width-1:0]         rd_data1_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data0_o <= mem_q[rd_addr0_i];
      rd_data1_o <= mem_q[rd_addr1_i];
    end
  end

endmodule

### rtl/bsfp4_front.sv
// front: configuration registers, byte intake, scale fill and element classification
module bsfp4_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [bsfp4_pkg::PaddrW-1:0]         paddr,
  input  logic [bsfp4_pkg::PdataW-1:0]         pwdata,
  output logic [bsfp4_pkg::PdataW-1:0]         prdata,
  output logic                                 pready,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           opcode_i,
  input  logic [bsfp4_pkg::ByteW-1:0]          key_byte_i,
  input  logic                                 queue_full_i,
  output logic                                 wr_en_o,
  output logic [bsfp4_pkg::StoreAddrW-1:0]     wr_addr_o,
  output logic [bsfp4_pkg::ByteW-1:0]          wr_data_o,
  output logic                                 rd_en_o,
  output logic [bsfp4_pkg::StoreAddrW-1:0]     rd_addr0_o,
  output logic [bsfp4_pkg::StoreAddrW-1:0]     rd_addr1_o,
  output logic                                 req_valid_o,
  output bsfp4_pkg::elem_req_t                 req_o
);

  localparam int unsigned PosW   = bsfp4_pkg::PosW;
  localparam int unsigned DimW   = bsfp4_pkg::DimW;
  localparam int unsigned FillW  = bsfp4_pkg::FillW;
  localparam int unsigned IdxW   = bsfp4_pkg::CodeIdxW;
  localparam int unsigned BlockW = bsfp4_pkg::BlockW;
  localparam int unsigned NibW   = bsfp4_pkg::NibW;

  function automatic logic [IdxW-1:0] code_index(logic col_mode, bsfp4_pkg::pos_t p,
                                                 logic [BlockW-1:0] blocks,
                                                 logic [DimW-1:0] cols);
    logic [PosW-1:0]      a;
    logic [DimW-1:0]      b;
    logic [PosW-1:0]      c;
    logic [PosW+DimW-1:0] prod;
    if (col_mode) begin
      a = p.row >> bsfp4_pkg::ScaleShift;
      b = cols;
      c = p.col;
    end else begin
      a = p.row;
      b = DimW'(blocks);
      c = p.col >> bsfp4_pkg::ScaleShift;
    end
    prod = a * b + (PosW + DimW)'(c);
    return prod[IdxW-1:0];
  endfunction

  function automatic bsfp4_pkg::pos_t advance(bsfp4_pkg::pos_t p, logic end_row);
    bsfp4_pkg::pos_t n;
    if (end_row) begin
      n.row = p.row + PosW'(1);
      n.col = '0;
    end else begin
      n.row = p.row;
      n.col = p.col + PosW'(1);
    end
    return n;
  endfunction

  function automatic logic at_row_end(bsfp4_pkg::pos_t p, logic [DimW-1:0] cols);
    return ({1'b0, p.col} + DimW'(1)) >= cols;
  endfunction

  function automatic logic at_last_row(bsfp4_pkg::pos_t p, logic [DimW-1:0] rows);
    return ({1'b0, p.row} + DimW'(1)) >= rows;
  endfunction

  logic [1:0]       mode_q;
  logic [DimW-1:0]  rows_q, cols_q;
  logic [FillW-1:0] fill_q, fill_d;
  bsfp4_pkg::pos_t  pos_q, pos_d;
  logic             done_q, done_d;

  logic             cfg_wr, accept;
  logic [DimW-1:0]  rows_c, cols_c;
  logic [DimW:0]    cols_rnd, rows_rnd;
  logic [BlockW-1:0] col_blocks, row_blocks;
  logic [FillW-1:0] need, remain;
  logic             use_scale, col_mode, fill_short;
  logic             take_scale, take_man, restart;

  logic [NibW-1:0]  nib0, nib1;
  bsfp4_pkg::pos_t  pos_a, pos_b, pos1, pos_c;
  logic             end_a, last_a, end_b, last_b, end1, last1;
  logic             act0, act1, done_mid;
  logic [IdxW-1:0]  idx_a, idx_b, idx1;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= bsfp4_pkg::ModeRow;
      rows_q <= DimW'(bsfp4_pkg::MaxDim);
      cols_q <= DimW'(bsfp4_pkg::MaxDim);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        bsfp4_pkg::RegMode: mode_q <= pwdata[1:0];
        bsfp4_pkg::RegRows: rows_q <= pwdata[DimW-1:0];
        bsfp4_pkg::RegCols: cols_q <= pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      bsfp4_pkg::RegMode: prdata = bsfp4_pkg::PdataW'(mode_q);
      bsfp4_pkg::RegRows: prdata = bsfp4_pkg::PdataW'(rows_q);
      bsfp4_pkg::RegCols: prdata = bsfp4_pkg::PdataW'(cols_q);
      default:            prdata = '0;
    endcase
  end

  // dimensions clamped to 1..MaxDim, then codes needed per mode
  always_comb begin
    if (rows_q == '0) rows_c = DimW'(1);
    else if (rows_q > DimW'(bsfp4_pkg::MaxDim)) rows_c = DimW'(bsfp4_pkg::MaxDim);
    else rows_c = rows_q;
    if (cols_q == '0) cols_c = DimW'(1);
    else if (cols_q > DimW'(bsfp4_pkg::MaxDim)) cols_c = DimW'(bsfp4_pkg::MaxDim);
    else cols_c = cols_q;
    cols_rnd   = {1'b0, cols_c} + (DimW + 1)'(bsfp4_pkg::ScaleBlock - 1);
    rows_rnd   = {1'b0, rows_c} + (DimW + 1)'(bsfp4_pkg::ScaleBlock - 1);
    col_blocks = BlockW'(cols_rnd >> bsfp4_pkg::ScaleShift);
    row_blocks = BlockW'(rows_rnd >> bsfp4_pkg::ScaleShift);
    col_mode   = (mode_q == bsfp4_pkg::ModeCol);
    use_scale  = (mode_q == bsfp4_pkg::ModeRow) || col_mode;
    if (mode_q == bsfp4_pkg::ModeRow) need = FillW'(rows_c) * FillW'(col_blocks);
    else if (col_mode) need = FillW'(row_blocks) * FillW'(cols_c);
    else need = '0;
  end

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign fill_short = fill_q < need;
  assign remain     = need - fill_q;
  assign take_scale = accept && (opcode_i == bsfp4_pkg::OpScale) && fill_short;
  assign take_man   = accept && (opcode_i == bsfp4_pkg::OpMantissa) && !fill_short;
  assign restart    = accept && (opcode_i == bsfp4_pkg::OpRestart);

  // fill stays a multiple of four until the final partial byte
  assign wr_en_o   = take_scale;
  assign wr_addr_o = fill_q[bsfp4_pkg::StoreAddrW+1:2];
  assign wr_data_o = key_byte_i;

  // low nibble first, the high nibble sees the position the low one leaves
  always_comb begin
    nib0     = key_byte_i[NibW-1:0];
    nib1     = key_byte_i[2*NibW-1:NibW];
    pos_a    = pos_q;
    end_a    = at_row_end(pos_a, cols_c);
    last_a   = end_a && at_last_row(pos_a, rows_c);
    pos_b    = advance(pos_a, end_a);
    end_b    = at_row_end(pos_b, cols_c);
    last_b   = end_b && at_last_row(pos_b, rows_c);
    act0     = !done_q && bsfp4_pkg::e2m1_ok(nib0);
    done_mid = done_q || (act0 && last_a);
    act1     = !done_mid && bsfp4_pkg::e2m1_ok(nib1);
    pos1     = act0 ? pos_b : pos_a;
    end1     = act0 ? end_b : end_a;
    last1    = act0 ? last_b : last_a;
    pos_c    = advance(pos1, end1);
    idx_a    = code_index(col_mode, pos_a, col_blocks, cols_c);
    idx_b    = code_index(col_mode, pos_b, col_blocks, cols_c);
    idx1     = act0 ? idx_b : idx_a;
  end

  always_comb begin
    req_o.mask           = {act1, act0};
    req_o.use_scale      = use_scale;
    req_o.slot[0].nib    = nib0;
    req_o.slot[0].pos    = pos_a;
    req_o.slot[0].last   = last_a;
    req_o.slot[0].sub    = idx_a[1:0];
    req_o.slot[1].nib    = nib1;
    req_o.slot[1].pos    = pos1;
    req_o.slot[1].last   = last1;
    req_o.slot[1].sub    = idx1[1:0];
  end

  assign req_valid_o = take_man && (act0 || act1);
  assign rd_en_o     = req_valid_o;
  assign rd_addr0_o  = idx_a[IdxW-1:2];
  assign rd_addr1_o  = idx1[IdxW-1:2];

  always_comb begin
    fill_d = fill_q;
    pos_d  = pos_q;
    done_d = done_q;
    if (restart) begin
      fill_d = '0;
      pos_d  = '0;
      done_d = 1'b0;
    end else if (take_scale) begin
      fill_d = (remain >= FillW'(4)) ? fill_q + FillW'(4) : need;
    end else if (take_man) begin
      if (act1) begin
        pos_d = last1 ? pos1 : pos_c;
      end else if (act0) begin
        pos_d = last_a ? pos_a : pos_b;
      end
      done_d = done_q || (act0 && last_a) || (act1 && last1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      pos_q  <= '0;
      done_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      pos_q  <= pos_d;
      done_q <= done_d;
    end
  end

endmodule

### rtl/bsfp4_back.sv
// back: scale lookup, dequantisation, element queue and output register
module bsfp4_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               req_valid_i,
  input  bsfp4_pkg::elem_req_t               req_i,
  input  logic [bsfp4_pkg::ByteW-1:0]        rd_data0_i,
  input  logic [bsfp4_pkg::ByteW-1:0]        rd_data1_i,
  output bsfp4_pkg::back_status_t            status_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [bsfp4_pkg::ValueW-1:0] element_value_o,
  output logic [bsfp4_pkg::PosW-1:0]         row_index_o,
  output logic [bsfp4_pkg::PosW-1:0]         column_index_o,
  output logic                               last_element_o
);

  localparam int unsigned ValueW = bsfp4_pkg::ValueW;
  localparam int unsigned QPtrW  = bsfp4_pkg::QPtrW;
  localparam int unsigned QCntW  = bsfp4_pkg::QCntW;

  // lookup stage, ram data arrives alongside
  logic                    r_valid_q;
  bsfp4_pkg::elem_req_t    r_req_q;
  logic [bsfp4_pkg::ByteW-1:0] rd_data [2];
  bsfp4_pkg::queue_entry_t entry;

  bsfp4_pkg::queue_entry_t q_mem_q [bsfp4_pkg::QueueDepth];
  logic [QPtrW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]        count_q;
  logic [1:0]              taken_q, taken_d;

  logic                    out_valid_q;
  bsfp4_pkg::elem_t        out_q;

  bsfp4_pkg::queue_entry_t head;
  logic [1:0]              head_mask, pick, rest;
  logic                    load, have, take, pop, push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else begin
      r_valid_q <= req_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i) begin
      r_req_q <= req_i;
    end
  end

  assign rd_data[0] = rd_data0_i;
  assign rd_data[1] = rd_data1_i;

  always_comb begin
    logic [1:0]               code;
    logic signed [ValueW-1:0] ext;
    entry.mask = r_req_q.mask;
    for (int s = 0; s < 2; s++) begin
      code = r_req_q.use_scale ?
             2'(rd_data[s] >> {r_req_q.slot[s].sub, 1'b0}) : 2'd0;
      ext  = ValueW'(bsfp4_pkg::e2m1_value(r_req_q.slot[s].nib));
      entry.slot[s].value = ext <<< code;
      entry.slot[s].pos   = r_req_q.slot[s].pos;
      entry.slot[s].last  = r_req_q.slot[s].last;
    end
  end

  assign push = r_valid_q;

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= entry;
    end
  end

  // serialise the up to two elements of the head entry
  always_comb begin
    head      = q_mem_q[rd_ptr_q];
    have      = count_q != '0;
    head_mask = head.mask & ~taken_q;
    pick      = head_mask[0] ? 2'b01 : 2'b10;
    rest      = head_mask & ~pick;
    load      = !out_valid_q || !out_stall_i;
    take      = load && have;
    pop       = take && (rest == 2'b00);
    taken_d   = taken_q;
    if (pop) taken_d = 2'b00;
    else if (take) taken_d = taken_q | pick;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      count_q     <= '0;
      taken_q     <= 2'b00;
      out_valid_q <= 1'b0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      if (pop) rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      count_q <= count_q + QCntW'(push) - QCntW'(pop);
      taken_q <= taken_d;
      if (load) out_valid_q <= have;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= head_mask[0] ? head.slot[0] : head.slot[1];
    end
  end

  // the lookup stage holds a credit so the queue never overflows
  assign status_o.r_valid = r_valid_q;
  assign status_o.count   = count_q;
  assign status_o.full    = (count_q + QCntW'(r_valid_q)) >= QCntW'(bsfp4_pkg::QueueDepth);

  assign out_valid_o     = out_valid_q;
  assign element_value_o = out_q.value;
  assign row_index_o     = out_q.pos.row;
  assign column_index_o  = out_q.pos.col;
  assign last_element_o  = out_q.last;

endmodule

### rtl/block_scaled_fp4_operand_expander.sv
// top level of the block-scaled fp4 operand expander
// takes one key byte per cycle while the element queue has room; a mantissa byte yields up
// to two elements, which pass the lookup stage and element queue into the output register
// one element leaves per cycle unless stalled; two accepted nibbles leave low nibble first
// reset clears the queue, fill count, position, done flag and registers; the scale store
// is not cleared; mantissa bytes are taken only once the fill reaches the codes needed
module block_scaled_fp4_operand_expander (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bsfp4_pkg::PaddrW-1:0]        paddr,
  input  logic [bsfp4_pkg::PdataW-1:0]        pwdata,
  output logic [bsfp4_pkg::PdataW-1:0]        prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          opcode_i,
  input  logic [bsfp4_pkg::ByteW-1:0]         key_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [bsfp4_pkg::ValueW-1:0] element_value_o,
  output logic [bsfp4_pkg::PosW-1:0]          row_index_o,
  output logic [bsfp4_pkg::PosW-1:0]          column_index_o,
  output logic                                last_element_o
);

  logic                                wr_en, rd_en, req_valid;
  logic [bsfp4_pkg::StoreAddrW-1:0]    wr_addr, rd_addr0, rd_addr1;
  logic [bsfp4_pkg::ByteW-1:0]         wr_data, rd_data0, rd_data1;
  bsfp4_pkg::elem_req_t                req;
  bsfp4_pkg::back_status_t             status;

  bsfp4_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .key_byte_i   (key_byte_i),
    .queue_full_i (status.full),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .rd_en_o      (rd_en),
    .rd_addr0_o   (rd_addr0),
    .rd_addr1_o   (rd_addr1),
    .req_valid_o  (req_valid),
    .req_o        (req)
  );

  bsfp4_ram #(
    .Width (bsfp4_pkg::ByteW),
    .Depth (bsfp4_pkg::StoreDepth)
  ) u_scale_ram (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .rd_en_i    (rd_en),
    .rd_addr0_i (rd_addr0),
    .rd_addr1_i (rd_addr1),
    .rd_data0_o (rd_data0),
    .rd_data1_o (rd_data1)
  );

  bsfp4_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (req_valid),
    .req_i           (req),
    .rd_data0_i      (rd_data0),
    .rd_data1_i      (rd_data1),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .element_value_o (element_value_o),
    .row_index_o     (row_index_o),
    .column_index_o  (column_index_o),
    .last_element_o  (last_element_o)
  );

  // a scale write and a mantissa lookup never share a cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) wr_en |-> !rd_en)
    else $error("scale write and lookup in the same cycle");

  // the queue never holds more entries than it has room for
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.count <= bsfp4_pkg::QCntW'(bsfp4_pkg::QueueDepth))
    else $error("element queue overflow");

  // every lookup lands in the back stage in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) rd_en |=> status.r_valid)
    else $error("lookup lost between front and back");

endmodule
